// ===== design/pts_pkg.sv =====
// Package for the process table scheduler.
// Request, state, status and policy codes, table record and result types.
// No dependencies.
package pts_pkg;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_PICK   = 3'd1;
  localparam logic [2:0] REQ_CREATE = 3'd2;
  localparam logic [2:0] REQ_SET    = 3'd3;
  localparam logic [2:0] REQ_WAKE   = 3'd4;
  localparam logic [2:0] REQ_SETWC  = 3'd5;
  localparam logic [2:0] REQ_READ   = 3'd6;
  localparam logic [2:0] REQ_RSVD   = 3'd7;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_ZOMBIE   = 3'd4;
  localparam logic [2:0] ST_RUNNING  = 3'd5;

  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_ACC  = 2'd1;
  localparam logic [1:0] POL_VRT  = 2'd2;
  localparam logic [1:0] POL_RSVD = 2'd3;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_NONE   = 2'd1;
  localparam logic [1:0] STS_UNUSED = 2'd2;

  localparam logic [1:0] WC_HIGH = 2'd0;
  localparam logic [1:0] WC_LOW  = 2'd2;

  localparam logic [6:0] FACTOR_HIGH   = 7'd75;
  localparam logic [6:0] FACTOR_NORMAL = 7'd100;
  localparam logic [6:0] FACTOR_LOW    = 7'd125;

  localparam logic [30:0] ACC_MAX      = 31'h7fffffff;
  localparam logic [3:0]  BASE_DEFAULT = 4'd5;
  localparam logic [1:0]  WC_DEFAULT   = 2'd1;

  typedef struct packed {
    logic [2:0]  st;
    logic [30:0] acc;
    logic [3:0]  base;
    logic [1:0]  wc;
    logic [31:0] run;
    logic [31:0] slp;
    logic [31:0] rdy;
  } rec_t;

  localparam rec_t REC_RESET = '{st: ST_UNUSED, acc: 31'd0, base: BASE_DEFAULT,
                                 wc: WC_DEFAULT, run: 32'd0, slp: 32'd0, rdy: 32'd0};

  typedef struct packed {
    logic        found;
    logic [5:0]  chosen_entry;
    logic [30:0] chosen_key;
    logic [31:0] run_ticks;
    logic [31:0] sleep_ticks;
    logic [31:0] ready_ticks;
    logic [1:0]  weight_class_out;
    logic [1:0]  status;
  } res_t;

  function automatic logic [6:0] factor_of(input logic [1:0] wc);
    logic [6:0] f;
    case (wc)
      WC_HIGH: f = FACTOR_HIGH;
      WC_LOW:  f = FACTOR_LOW;
      default: f = FACTOR_NORMAL;
    endcase
    return f;
  endfunction

endpackage

// ===== design/pts_if.sv =====
// Request and response channel interfaces of the process table scheduler.
// Depends on nothing; widths follow the fixed field widths.
interface pts_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [5:0] entry;
  logic [2:0] new_state;
  logic [1:0] value;
  modport source(output valid, req_type, entry, new_state, value, input ready);
  modport sink(input valid, req_type, entry, new_state, value, output ready);
endinterface

interface pts_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [5:0]  chosen_entry;
  logic [30:0] chosen_key;
  logic [31:0] run_ticks;
  logic [31:0] sleep_ticks;
  logic [31:0] ready_ticks;
  logic [1:0]  weight_class_out;
  logic [1:0]  status;
  modport source(output valid, found, chosen_entry, chosen_key, run_ticks, sleep_ticks,
                 ready_ticks, weight_class_out, status, input ready);
  modport sink(input valid, found, chosen_entry, chosen_key, run_ticks, sleep_ticks,
               ready_ticks, weight_class_out, status, output ready);
endinterface

// ===== design/pts_table.sv =====
// Task table memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as the reset record. Uses pts_pkg.
module pts_table #(
  parameter int ENTRIES = 64,
  parameter int IW = $clog2(ENTRIES)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [IW-1:0]  rd_addr,
  input  logic           wr_en,
  input  logic [IW-1:0]  wr_addr,
  input  pts_pkg::rec_t  wr_data,
  output pts_pkg::rec_t  rd_data
);

  pts_pkg::rec_t mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  pts_pkg::rec_t rd_q;
  logic vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = vld_q ? rd_q : pts_pkg::REC_RESET;

endmodule

// ===== design/pts_div.sv =====
// Restoring divider for weighted runtime, one quotient bit per cycle.
// Quotient never exceeds the largest weight factor, so 7 bits suffice. Uses no package.
module pts_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [38:0] num,
  input  logic [33:0] den,
  output logic        done,
  output logic [6:0]  quo
);

  logic        busy;
  logic [2:0]  step;
  logic [38:0] rem;
  logic [33:0] dv;
  logic [40:0] sh;

  assign sh = 41'(dv) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 3'd0);
      if (start) begin
        busy <= 1'b1;
        step <= 3'd6;
        rem  <= num;
        dv   <= den;
        quo  <= '0;
      end else if (busy) begin
        if (41'(rem) >= sh) begin
          rem       <= rem - sh[38:0];
          quo[step] <= 1'b1;
        end
        if (step == 3'd0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 3'd1;
        end
      end
    end
  end

endmodule

// ===== design/process_table_scheduler_top.sv =====
// Process table scheduler, top level. Uses pts_pkg, pts_if, pts_table, pts_div.
//
// Requests arrive on req_ch (valid/ready); each produces exactly one response
// transfer on rsp_ch. policy_we/policy_wdata write the policy register; the user
// must write it only while idle, which the block does not enforce. One request is
// worked at a time; req_ch.ready is high only when idle, even while an earlier
// response still waits in the output register. Create, set state, wake, set
// weight class and read stats read one entry and may write it back; request type
// 7, and pick with policy 3, go straight to the response; tick reads and writes
// every entry; pick round robin examines entries from the round robin pointer up
// to the first runnable one, or all entries if none is runnable; pick least
// accumulator examines every entry; pick least weighted runtime does the same and
// also runs the divider (7 quotient bits) for each runnable entry with nonzero
// run count.
// Reset clears control state and the table valid bits, so every entry reads as
// unused with default fields; no clearing pass is needed. If the receiver stalls,
// the finished response holds in the output register; a further request is
// accepted and worked, and waits before its response until the register frees.
module process_table_scheduler_top #(
  parameter int ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             policy_we,
  input  logic [1:0]       policy_wdata,
  pts_req_if.sink          req_ch,
  pts_rsp_if.source        rsp_ch
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW:0]   LAST = (IW+1)'(ENTRIES - 1);
  localparam logic [IW-1:0] TOP_ADDR = IW'(ENTRIES - 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RD     = 11'b00000000010,
    S_OP     = 11'b00000000100,
    S_TK_RD  = 11'b00000001000,
    S_TK_WR  = 11'b00000010000,
    S_PK_RD  = 11'b00000100000,
    S_PK_EV  = 11'b00001000000,
    S_PK_DIV = 11'b00010000000,
    S_FIN_RD = 11'b00100000000,
    S_FIN_WR = 11'b01000000000,
    S_PUSH   = 11'b10000000000
  } state_t;

  state_t state;
  logic [1:0]    policy;
  logic [2:0]    req_q;
  logic [5:0]    e_q;
  logic [2:0]    ns_q;
  logic [1:0]    val_q;
  logic [IW-1:0] rr_ptr;
  logic [IW-1:0] addr;
  logic [IW:0]   cnt;
  logic          have;
  logic [IW-1:0] best;
  logic [30:0]   bestkey;
  logic [1:0]    rcount;
  pts_pkg::res_t res;
  pts_pkg::res_t out_r;
  logic          out_v;

  pts_pkg::rec_t rdata;
  pts_pkg::rec_t wdata;
  logic          wr_en;

  logic          div_start;
  logic          div_done;
  logic [6:0]    quo;
  logic [38:0]   div_num;
  logic [33:0]   div_den;

  logic          accept;
  logic          e_ok;
  logic          used;
  logic          ev_run;
  logic          ev_take;
  logic          need_div;
  logic [30:0]   key_now;
  logic          h_n;
  logic [IW-1:0] b_n;
  logic [30:0]   k_n;
  logic          last;
  logic [IW-1:0] addr_inc;
  logic [31:0]   wake_sum;

  pts_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
    .clk(clk), .rst(rst), .rd_addr(addr), .wr_en(wr_en), .wr_addr(addr),
    .wr_data(wdata), .rd_data(rdata)
  );

  pts_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  assign req_ch.ready = (state == S_IDLE);
  assign accept       = req_ch.valid && req_ch.ready;

  assign e_ok     = 32'(e_q) < 32'(ENTRIES);
  assign used     = e_ok && (rdata.st != pts_pkg::ST_UNUSED);
  assign addr_inc = (addr == TOP_ADDR) ? '0 : addr + IW'(1);
  assign wake_sum = 32'(rdata.acc) + 32'(rdata.base);

  assign div_num  = 39'(rdata.run) * 39'(pts_pkg::factor_of(rdata.wc));
  assign div_den  = 34'(rdata.run) + 34'(rdata.slp) + 34'(rdata.rdy);
  assign ev_run   = (rdata.st == pts_pkg::ST_RUNNABLE);
  assign need_div = ev_run && (policy == pts_pkg::POL_VRT) && (rdata.run != 32'd0);
  assign div_start = (state == S_PK_EV) && need_div;

  always_comb begin
    if (state == S_PK_DIV) begin
      key_now = 31'(quo);
    end else if (policy == pts_pkg::POL_ACC) begin
      key_now = rdata.acc;
    end else begin
      key_now = 31'd0;
    end
  end

  assign ev_take = ev_run && (!have || (key_now < bestkey));
  assign h_n     = have || ev_run;
  assign b_n     = ev_take ? addr : best;
  assign k_n     = ev_take ? key_now : bestkey;
  assign last    = (cnt == LAST) || ((policy == pts_pkg::POL_RR) && h_n);

  always_comb begin
    wr_en = 1'b0;
    wdata = rdata;
    unique case (state)
      S_OP: begin
        case (req_q)
          pts_pkg::REQ_CREATE: begin
            if (e_ok && !used) begin
              wr_en = 1'b1;
              wdata = '{st: pts_pkg::ST_RUNNABLE, acc: 31'd0, base: pts_pkg::BASE_DEFAULT,
                        wc: val_q, run: 32'd0, slp: 32'd0, rdy: 32'd0};
            end
          end
          pts_pkg::REQ_SET: begin
            if (e_ok && (ns_q <= pts_pkg::ST_ZOMBIE)) begin
              wr_en    = 1'b1;
              wdata.st = ns_q;
              if (ns_q == pts_pkg::ST_ZOMBIE) begin
                wdata.base = 4'd0;
                wdata.acc  = pts_pkg::ACC_MAX;
              end
            end
          end
          pts_pkg::REQ_WAKE: begin
            if (used && (rdata.st == pts_pkg::ST_SLEEPING)) begin
              wr_en     = 1'b1;
              wdata.st  = pts_pkg::ST_RUNNABLE;
              wdata.acc = (wake_sum > 32'(pts_pkg::ACC_MAX)) ? pts_pkg::ACC_MAX
                                                             : wake_sum[30:0];
            end
          end
          pts_pkg::REQ_SETWC: begin
            if (used) begin
              wr_en    = 1'b1;
              wdata.wc = val_q;
            end
          end
          default: ;
        endcase
      end
      S_TK_WR: begin
        case (rdata.st)
          pts_pkg::ST_RUNNING: begin
            wr_en     = 1'b1;
            wdata.run = (rdata.run == 32'hffffffff) ? rdata.run : rdata.run + 32'd1;
          end
          pts_pkg::ST_SLEEPING: begin
            wr_en     = 1'b1;
            wdata.slp = (rdata.slp == 32'hffffffff) ? rdata.slp : rdata.slp + 32'd1;
          end
          pts_pkg::ST_RUNNABLE: begin
            wr_en     = 1'b1;
            wdata.rdy = (rdata.rdy == 32'hffffffff) ? rdata.rdy : rdata.rdy + 32'd1;
          end
          default: ;
        endcase
      end
      S_FIN_WR: begin
        wr_en    = 1'b1;
        wdata.st = pts_pkg::ST_RUNNING;
        if ((policy == pts_pkg::POL_ACC) && (rcount == 2'd1)) begin
          wdata.acc = 31'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      policy <= pts_pkg::POL_RR;
      rr_ptr <= '0;
      out_v  <= 1'b0;
      res    <= '0;
      have   <= 1'b0;
      rcount <= 2'd0;
      cnt    <= '0;
      addr   <= '0;
    end else begin
      if (policy_we) begin
        policy <= policy_wdata;
      end
      if ((state == S_PUSH) && (!out_v || rsp_ch.ready)) begin
        out_v <= 1'b1;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        out_v <= 1'b0;
      end
      unique case (state) inside
        S_IDLE: begin
          if (accept) begin
            req_q  <= req_ch.req_type;
            e_q    <= req_ch.entry;
            ns_q   <= req_ch.new_state;
            val_q  <= req_ch.value;
            cnt    <= '0;
            have   <= 1'b0;
            rcount <= 2'd0;
            case (req_ch.req_type) inside
              pts_pkg::REQ_TICK: begin
                addr  <= '0;
                state <= S_TK_RD;
              end
              pts_pkg::REQ_PICK: begin
                if (policy == pts_pkg::POL_RR) begin
                  addr  <= rr_ptr;
                  state <= S_PK_RD;
                end else if ((policy == pts_pkg::POL_ACC) || (policy == pts_pkg::POL_VRT)) begin
                  addr  <= '0;
                  state <= S_PK_RD;
                end else begin
                  res.status <= pts_pkg::STS_NONE;
                  state      <= S_PUSH;
                end
              end
              pts_pkg::REQ_CREATE, pts_pkg::REQ_SET, pts_pkg::REQ_WAKE,
              pts_pkg::REQ_SETWC, pts_pkg::REQ_READ: begin
                addr  <= IW'(req_ch.entry);
                state <= S_RD;
              end
              default: state <= S_PUSH;
            endcase
          end
        end
        S_RD: state <= S_OP;
        S_OP: begin
          if (req_q == pts_pkg::REQ_READ) begin
            res.chosen_entry <= e_q;
            if (used) begin
              res.run_ticks        <= rdata.run;
              res.sleep_ticks      <= rdata.slp;
              res.ready_ticks      <= rdata.rdy;
              res.weight_class_out <= rdata.wc;
            end
          end
          if (!used && ((req_q == pts_pkg::REQ_READ) || (req_q == pts_pkg::REQ_WAKE) ||
                        (req_q == pts_pkg::REQ_SETWC))) begin
            res.status <= pts_pkg::STS_UNUSED;
          end
          state <= S_PUSH;
        end
        S_TK_RD: state <= S_TK_WR;
        S_TK_WR: begin
          if (cnt == LAST) begin
            state <= S_PUSH;
          end else begin
            addr  <= addr_inc;
            cnt   <= cnt + (IW+1)'(1);
            state <= S_TK_RD;
          end
        end
        S_PK_RD: state <= S_PK_EV;
        S_PK_EV, S_PK_DIV: begin
          if (state == S_PK_EV && need_div) begin
            state <= S_PK_DIV;
          end else if (state == S_PK_EV || div_done) begin
            have    <= h_n;
            best    <= b_n;
            bestkey <= k_n;
            if (ev_run && (rcount != 2'd2)) begin
              rcount <= rcount + 2'd1;
            end
            if (last) begin
              if (h_n) begin
                addr  <= b_n;
                state <= S_FIN_RD;
              end else begin
                res.status <= pts_pkg::STS_NONE;
                state      <= S_PUSH;
              end
            end else begin
              addr  <= addr_inc;
              cnt   <= cnt + (IW+1)'(1);
              state <= S_PK_RD;
            end
          end
        end
        S_FIN_RD: state <= S_FIN_WR;
        S_FIN_WR: begin
          res.found        <= 1'b1;
          res.chosen_entry <= 6'(best);
          res.chosen_key   <= bestkey;
          if (policy == pts_pkg::POL_RR) begin
            rr_ptr <= (best == TOP_ADDR) ? '0 : best + IW'(1);
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_v || rsp_ch.ready) begin
            out_r <= res;
            res   <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp_ch.valid            = out_v;
  assign rsp_ch.found            = out_r.found;
  assign rsp_ch.chosen_entry     = out_r.chosen_entry;
  assign rsp_ch.chosen_key       = out_r.chosen_key;
  assign rsp_ch.run_ticks        = out_r.run_ticks;
  assign rsp_ch.sleep_ticks      = out_r.sleep_ticks;
  assign rsp_ch.ready_ticks      = out_r.ready_ticks;
  assign rsp_ch.weight_class_out = out_r.weight_class_out;
  assign rsp_ch.status           = out_r.status;

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_ch.valid && rsp_ch.found |-> rsp_ch.status == pts_pkg::STS_OK)
    else $error("found response with nonzero status");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_PK_DIV)
    else $error("divider result outside divide wait");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request transfer did not start work");

  a_fin_write: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN_WR |-> wr_en && have)
    else $error("pick finish without chosen entry");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for process_table_scheduler_top: random and directed requests,
// checked against a behavioral table predictor in a scoreboard class.
// Depends on pts_pkg, pts_if and the scheduler RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int N = 64;
  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic policy_we = 1'b0;
  logic [1:0] policy_wdata = '0;
  int errors = 0;
  bit quiet = 1'b0;
  int wd = 0;

  pts_req_if req_ch();
  pts_rsp_if rsp_ch();

  process_table_scheduler_top dut (
    .clk(clk), .rst(rst), .policy_we(policy_we), .policy_wdata(policy_wdata),
    .req_ch(req_ch), .rsp_ch(rsp_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  class sched_board;
    pts_pkg::rec_t tbl[N];
    logic [5:0] rr_ptr;
    logic [1:0] pol;
    pts_pkg::res_t pending[$];

    function void clear();
      for (int i = 0; i < N; i++) tbl[i] = pts_pkg::REC_RESET;
      rr_ptr = '0;
      pol = pts_pkg::POL_RR;
    endfunction

    function logic [31:0] sat(input logic [31:0] v);
      return (v == 32'hffffffff) ? v : v + 32'd1;
    endfunction

    function logic [30:0] vrt(input int i);
      logic [63:0] f, tot;
      f = (tbl[i].wc == pts_pkg::WC_HIGH) ? 64'd75 :
          (tbl[i].wc == pts_pkg::WC_LOW) ? 64'd125 : 64'd100;
      if (tbl[i].run == 0) return '0;
      tot = 64'(tbl[i].run) + 64'(tbl[i].slp) + 64'(tbl[i].rdy);
      return 31'((64'(tbl[i].run) * f) / tot);
    endfunction

    function void note_request(input logic [2:0] rq, input logic [5:0] e,
                               input logic [2:0] ns, input logic [1:0] v);
      pts_pkg::res_t r;
      bit have, used;
      int best, cnt;
      logic [30:0] key, bkey;
      logic [31:0] s;
      r = '0;
      used = tbl[e].st != pts_pkg::ST_UNUSED;
      have = 0; best = 0; cnt = 0; bkey = '0;
      case (rq)
        pts_pkg::REQ_TICK: begin
          for (int i = 0; i < N; i++) begin
            if (tbl[i].st == pts_pkg::ST_RUNNING) tbl[i].run = sat(tbl[i].run);
            else if (tbl[i].st == pts_pkg::ST_SLEEPING) tbl[i].slp = sat(tbl[i].slp);
            else if (tbl[i].st == pts_pkg::ST_RUNNABLE) tbl[i].rdy = sat(tbl[i].rdy);
          end
        end
        pts_pkg::REQ_PICK: begin
          if (pol == pts_pkg::POL_RR) begin
            for (int k = 0; k < N && !have; k++) begin
              int i;
              i = (rr_ptr + k) % N;
              if (tbl[i].st == pts_pkg::ST_RUNNABLE) begin
                have = 1; best = i;
              end
            end
            if (have) rr_ptr = 6'(best + 1);
          end else if (pol == pts_pkg::POL_ACC || pol == pts_pkg::POL_VRT) begin
            for (int i = 0; i < N; i++) begin
              if (tbl[i].st != pts_pkg::ST_RUNNABLE) continue;
              cnt++;
              key = (pol == pts_pkg::POL_ACC) ? tbl[i].acc : vrt(i);
              if (!have || key < bkey) begin
                have = 1; best = i; bkey = key;
              end
            end
            if (have && pol == pts_pkg::POL_ACC && cnt == 1) tbl[best].acc = '0;
          end
          if (have) begin
            tbl[best].st = pts_pkg::ST_RUNNING;
            r.found = 1'b1;
            r.chosen_entry = 6'(best);
            r.chosen_key = bkey;
          end else r.status = pts_pkg::STS_NONE;
        end
        pts_pkg::REQ_CREATE: begin
          if (!used) begin
            tbl[e] = pts_pkg::REC_RESET;
            tbl[e].st = pts_pkg::ST_RUNNABLE;
            tbl[e].wc = v;
          end
        end
        pts_pkg::REQ_SET: begin
          if (ns <= pts_pkg::ST_ZOMBIE) begin
            tbl[e].st = ns;
            if (ns == pts_pkg::ST_ZOMBIE) begin
              tbl[e].base = '0;
              tbl[e].acc = pts_pkg::ACC_MAX;
            end
          end
        end
        pts_pkg::REQ_WAKE: begin
          if (!used) r.status = pts_pkg::STS_UNUSED;
          else if (tbl[e].st == pts_pkg::ST_SLEEPING) begin
            s = 32'(tbl[e].acc) + 32'(tbl[e].base);
            tbl[e].st = pts_pkg::ST_RUNNABLE;
            tbl[e].acc = (s > 32'(pts_pkg::ACC_MAX)) ? pts_pkg::ACC_MAX : s[30:0];
          end
        end
        pts_pkg::REQ_SETWC: begin
          if (!used) r.status = pts_pkg::STS_UNUSED;
          else tbl[e].wc = v;
        end
        pts_pkg::REQ_READ: begin
          r.chosen_entry = e;
          if (!used) r.status = pts_pkg::STS_UNUSED;
          else begin
            r.run_ticks = tbl[e].run;
            r.sleep_ticks = tbl[e].slp;
            r.ready_ticks = tbl[e].rdy;
            r.weight_class_out = tbl[e].wc;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task check_result(input pts_pkg::res_t got);
      pts_pkg::res_t w;
      if (pending.size() == 0) begin
        report("unexpected transfer", 32'(got.status), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.found !== w.found) report("found", 32'(got.found), 32'(w.found));
      if (got.chosen_entry !== w.chosen_entry)
        report("chosen_entry", 32'(got.chosen_entry), 32'(w.chosen_entry));
      if (got.chosen_key !== w.chosen_key)
        report("chosen_key", 32'(got.chosen_key), 32'(w.chosen_key));
      if (got.run_ticks !== w.run_ticks) report("run_ticks", got.run_ticks, w.run_ticks);
      if (got.sleep_ticks !== w.sleep_ticks)
        report("sleep_ticks", got.sleep_ticks, w.sleep_ticks);
      if (got.ready_ticks !== w.ready_ticks)
        report("ready_ticks", got.ready_ticks, w.ready_ticks);
      if (got.weight_class_out !== w.weight_class_out)
        report("weight_class_out", 32'(got.weight_class_out), 32'(w.weight_class_out));
      if (got.status !== w.status) report("status", 32'(got.status), 32'(w.status));
    endtask
  endclass

  sched_board sb;

  // response side: random stall bursts, checks on transfer
  always @(posedge clk) begin
    pts_pkg::res_t got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.found = rsp_ch.found;
        got.chosen_entry = rsp_ch.chosen_entry;
        got.chosen_key = rsp_ch.chosen_key;
        got.run_ticks = rsp_ch.run_ticks;
        got.sleep_ticks = rsp_ch.sleep_ticks;
        got.ready_ticks = rsp_ch.ready_ticks;
        got.weight_class_out = rsp_ch.weight_class_out;
        got.status = rsp_ch.status;
        sb.check_result(got);
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet || rst) rsp_ch.ready <= 1'b1;
      else if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 3);
        rsp_ch.ready <= 1'b0;
      end else rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WD_LIMIT) begin
      $display("FAIL process_table_scheduler_top");
      $finish;
    end
  end

  task automatic send(input logic [2:0] rq, input logic [5:0] e,
                      input logic [2:0] ns, input logic [1:0] v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rq;
    req_ch.entry <= e;
    req_ch.new_state <= ns;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(rq, e, ns, v);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_policy(input logic [1:0] p);
    drain();
    policy_we <= 1'b1;
    policy_wdata <= p;
    @(posedge clk);
    policy_we <= 1'b0;
    sb.pol = p;
  endtask

  task automatic rand_req();
    int r;
    logic [5:0] e;
    r = $urandom_range(0, 99);
    e = (r % 3 == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 11));
    if (r < 22) send(pts_pkg::REQ_TICK, e, 3'($urandom), 2'($urandom));
    else if (r < 40) send(pts_pkg::REQ_PICK, e, 3'($urandom), 2'($urandom));
    else if (r < 52) send(pts_pkg::REQ_CREATE, e, 3'($urandom), 2'($urandom));
    else if (r < 66) send(pts_pkg::REQ_SET, e, 3'($urandom_range(0, 5)), 2'($urandom));
    else if (r < 76) send(pts_pkg::REQ_WAKE, e, 3'($urandom), 2'($urandom));
    else if (r < 84) send(pts_pkg::REQ_SETWC, e, 3'($urandom), 2'($urandom));
    else if (r < 99) send(pts_pkg::REQ_READ, e, 3'($urandom), 2'($urandom));
    else send(pts_pkg::REQ_RSVD, e, 3'($urandom), 2'($urandom));
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.entry = '0;
    req_ch.new_state = '0;
    req_ch.value = '0;
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed
    send(pts_pkg::REQ_PICK, 6'd0, 3'd0, 2'd0);
    send(pts_pkg::REQ_READ, 6'd63, 3'd0, 2'd0);
    send(pts_pkg::REQ_WAKE, 6'd5, 3'd0, 2'd0);
    send(pts_pkg::REQ_SETWC, 6'd5, 3'd0, 2'd2);
    send(pts_pkg::REQ_CREATE, 6'd0, 3'd0, pts_pkg::WC_HIGH);
    send(pts_pkg::REQ_CREATE, 6'd63, 3'd0, 2'd3);
    send(pts_pkg::REQ_CREATE, 6'd0, 3'd0, pts_pkg::WC_LOW);
    send(pts_pkg::REQ_CREATE, 6'd7, 3'd0, pts_pkg::WC_LOW);
    send(pts_pkg::REQ_TICK, 6'd0, 3'd0, 2'd0);
    send(pts_pkg::REQ_PICK, 6'd0, 3'd0, 2'd0);
    send(pts_pkg::REQ_SET, 6'd7, pts_pkg::ST_SLEEPING, 2'd0);
    send(pts_pkg::REQ_SET, 6'd7, 3'd7, 2'd0);
    send(pts_pkg::REQ_TICK, 6'd0, 3'd0, 2'd0);
    send(pts_pkg::REQ_WAKE, 6'd7, 3'd0, 2'd0);
    send(pts_pkg::REQ_WAKE, 6'd0, 3'd0, 2'd0);
    send(pts_pkg::REQ_SET, 6'd63, pts_pkg::ST_ZOMBIE, 2'd0);
    send(pts_pkg::REQ_SET, 6'd63, pts_pkg::ST_SLEEPING, 2'd0);
    send(pts_pkg::REQ_WAKE, 6'd63, 3'd0, 2'd0);
    send(pts_pkg::REQ_READ, 6'd0, 3'd0, 2'd0);
    send(pts_pkg::REQ_READ, 6'd63, 3'd0, 2'd0);
    send(pts_pkg::REQ_RSVD, 6'd63, 3'd7, 2'd3);
    // hold off until the pipeline is empty
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_policy(ph == 7 ? pts_pkg::POL_RSVD : 2'(ph % 3));
      if (ph == 6) quiet = 1'b1;
      for (int n = 0; n < (ph == 7 ? 30 : 115); n++) rand_req();
    end
    drain();
    if (errors == 0) $display("PASS process_table_scheduler_top");
    else $display("FAIL process_table_scheduler_top");
    $finish;
  end

endmodule

// ===== process_table_scheduler_top.f =====
design/pts_pkg.sv
design/pts_if.sv
design/pts_table.sv
design/pts_div.sv
design/process_table_scheduler_top.sv
tb/sv/tb_top.sv
